// ----- rtl/btx_pkg.sv -----
package btx_pkg;

  localparam int OP_W   = 2;
  localparam int VAL_W  = 31;
  localparam int STAT_W = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;

endpackage

// ----- rtl/btx_op_if.sv -----
interface btx_op_if import btx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [VAL_W-1:0]  value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

// ----- rtl/btx_res_if.sv -----
interface btx_res_if import btx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  max_xor;
  logic [STAT_W-1:0] status;

  modport source (output valid, output max_xor, output status, input ready);
  modport sink   (input valid, input max_xor, input status, output ready);
endinterface

// ----- rtl/binary_trie_max_xor_top.sv -----
// channel   | direction | fields
// in_op     | sink      | operation, value
// out_res   | source    | max_xor, status
//
// query: one node memory read per trie level
// insert/erase: a check walk, then a write walk; an early reject ends after the check walk
// after reset a clearing pass over all NODES entries builds the key-0 chain and the free stack
// the next operation is taken while a result still waits in the output register
module binary_trie_max_xor_top import btx_pkg::*; #(
  parameter int KEY_BITS   = 31,
  parameter int NODES      = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  btx_op_if.sink    in_op,
  btx_res_if.source out_res
);

  localparam int AW = $clog2(NODES);
  localparam int FW = AW + 1;
  localparam int LW = $clog2(KEY_BITS + 1);
  localparam int CB = COUNT_BITS;
  localparam int EW = 2 * AW + CB;
  localparam int XW = KEY_BITS + VAL_W;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_QRY  = 3'd3;
  localparam logic [2:0] S_WRI  = 3'd4;
  localparam logic [2:0] S_ALC  = 3'd5;
  localparam logic [2:0] S_WRE  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  // node entry: {link1, link0, count}
  logic [EW-1:0] nmem [NODES];
  logic [AW-1:0] flmem [NODES];

  logic [EW-1:0] nm_q;
  logic [AW-1:0] nm_ra, nm_wa;
  logic [EW-1:0] nm_wd;
  logic          nm_we;
  logic [AW-1:0] fl_q;
  logic [AW-1:0] fl_ra, fl_wa, fl_wd;
  logic          fl_we;

  logic [2:0]          st_r, st_nxt;
  logic [LW-1:0]       lvl_r, lvl_nxt;
  logic                leaf_r, leaf_nxt;
  logic                first_r, first_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [AW-1:0]       cur_r, cur_nxt;
  logic [AW-1:0]       pa_r, pa_nxt;
  logic                pb_r, pb_nxt;
  logic [EW-1:0]       par_r, par_nxt;
  logic [KEY_BITS-1:0] best_r, best_nxt;
  logic [FW-1:0]       fc_r, fc_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [VAL_W-1:0]    res_max_r, res_max_nxt;
  logic [STAT_W-1:0]   res_st_r, res_st_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]    out_max_r, out_max_nxt;
  logic [STAT_W-1:0]   out_st_r, out_st_nxt;

  logic [XW-1:0]       val_x, best_x;
  logic [KEY_BITS-1:0] key_sh, one_sh;
  logic                kb;
  logic [CB-1:0]       r_cnt, cnt_inc, cnt_dec;
  logic [AW-1:0]       r_l0, r_l1, rl_b, rl_o;
  logic [LW-1:0]       needed;
  logic                decide;

  always_ff @(posedge clk) begin
    nm_q <= nmem[nm_ra];
    if (nm_we) begin
      nmem[nm_wa] <= nm_wd;
    end
    fl_q <= flmem[fl_ra];
    if (fl_we) begin
      flmem[fl_wa] <= fl_wd;
    end
  end

  assign val_x  = XW'(in_op.value);
  assign key_sh = key_r >> lvl_r;
  assign kb     = key_sh[0];
  assign one_sh = KEY_BITS'(1) << lvl_r;

  assign r_cnt   = nm_q[CB-1:0];
  assign r_l0    = nm_q[CB +: AW];
  assign r_l1    = nm_q[CB + AW +: AW];
  assign rl_b    = kb ? r_l1 : r_l0;
  assign rl_o    = kb ? r_l0 : r_l1;
  assign cnt_inc = (&r_cnt) ? r_cnt : r_cnt + CB'(1);
  assign cnt_dec = (r_cnt == '0) ? r_cnt : r_cnt - CB'(1);

  always_comb begin
    st_nxt        = st_r;
    lvl_nxt       = lvl_r;
    leaf_nxt      = leaf_r;
    first_nxt     = first_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    cur_nxt       = cur_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    par_nxt       = par_r;
    best_nxt      = best_r;
    fc_nxt        = fc_r;
    clr_nxt       = clr_r;
    res_max_nxt   = res_max_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_max_nxt   = out_max_r;
    out_st_nxt    = out_st_r;
    nm_ra         = cur_r;
    nm_we         = 1'b0;
    nm_wa         = cur_r;
    nm_wd         = nm_q;
    fl_we         = 1'b0;
    fl_wa         = fc_r[AW-1:0];
    fl_wd         = cur_r;
    needed        = '0;
    decide        = 1'b0;
    best_x        = '0;

    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      S_CLR: begin
        nm_we = 1'b1;
        nm_wa = clr_r;
        nm_wd = '0;
        if (clr_r < AW'(KEY_BITS)) begin
          nm_wd[CB +: AW] = clr_r + AW'(1);
        end
        if (clr_r != '0 && clr_r <= AW'(KEY_BITS)) begin
          nm_wd[CB-1:0] = CB'(1);
        end
        fl_we   = 1'b1;
        fl_wa   = clr_r;
        fl_wd   = AW'(NODES - 1) - clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(NODES - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_op.valid) begin
          op_nxt    = in_op.operation;
          key_nxt   = val_x[KEY_BITS-1:0];
          lvl_nxt   = LW'(KEY_BITS - 1);
          leaf_nxt  = 1'b0;
          first_nxt = 1'b1;
          best_nxt  = '0;
          cur_nxt   = '0;
          nm_ra     = '0;
          unique case (in_op.operation) inside
            OP_INSERT, OP_ERASE: st_nxt = S_CHK;
            OP_QUERY:            st_nxt = S_QRY;
            default: begin
              res_max_nxt = '0;
              res_st_nxt  = ST_OK;
              st_nxt      = S_FIN;
            end
          endcase
        end
      end
      S_QRY: begin
        if (rl_o == '0 && rl_b == '0) begin
          res_max_nxt = '0;
          res_st_nxt  = ST_OK;
          st_nxt      = S_FIN;
        end else begin
          if (rl_o != '0) begin
            nm_ra    = rl_o;
            best_nxt = best_r | one_sh;
          end else begin
            nm_ra = rl_b;
          end
          cur_nxt = nm_ra;
          if (lvl_r == '0) begin
            best_x      = XW'(best_nxt);
            res_max_nxt = best_x[VAL_W-1:0];
            res_st_nxt  = ST_OK;
            st_nxt      = S_FIN;
          end else begin
            lvl_nxt = lvl_r - LW'(1);
          end
        end
      end
      S_CHK: begin
        if (rl_b == '0) begin
          if (op_r == OP_ERASE) begin
            res_max_nxt = '0;
            res_st_nxt  = ST_ABSENT;
            st_nxt      = S_FIN;
          end else begin
            needed = lvl_r + LW'(1);
            decide = 1'b1;
          end
        end else if (lvl_r == '0) begin
          if (op_r == OP_ERASE) begin
            nm_ra     = '0;
            cur_nxt   = '0;
            lvl_nxt   = LW'(KEY_BITS - 1);
            leaf_nxt  = 1'b0;
            first_nxt = 1'b1;
            st_nxt    = S_WRE;
          end else begin
            decide = 1'b1;
          end
        end else begin
          nm_ra   = rl_b;
          cur_nxt = rl_b;
          lvl_nxt = lvl_r - LW'(1);
        end
        if (decide) begin
          if ((FW + LW)'(needed) > (FW + LW)'(fc_r)) begin
            res_max_nxt = '0;
            res_st_nxt  = ST_FULL;
            st_nxt      = S_FIN;
          end else begin
            nm_ra     = '0;
            cur_nxt   = '0;
            lvl_nxt   = LW'(KEY_BITS - 1);
            leaf_nxt  = 1'b0;
            first_nxt = 1'b1;
            st_nxt    = S_WRI;
          end
        end
      end
      S_WRI: begin
        nm_we = 1'b1;
        nm_wa = cur_r;
        nm_wd = {r_l1, r_l0, (first_r ? r_cnt : cnt_inc)};
        first_nxt = 1'b0;
        if (leaf_r) begin
          res_max_nxt = '0;
          res_st_nxt  = ST_OK;
          st_nxt      = S_FIN;
        end else begin
          if (rl_b != '0) begin
            nm_ra   = rl_b;
            cur_nxt = rl_b;
          end else begin
            // first missing link: hang the top of the free stack here
            if (kb) begin
              nm_wd[CB + AW +: AW] = fl_q;
            end else begin
              nm_wd[CB +: AW] = fl_q;
            end
            cur_nxt = fl_q;
            fc_nxt  = fc_r - FW'(1);
            st_nxt  = S_ALC;
          end
          if (lvl_r == '0) begin
            leaf_nxt = 1'b1;
          end else begin
            lvl_nxt = lvl_r - LW'(1);
          end
        end
      end
      S_ALC: begin
        nm_we = 1'b1;
        nm_wa = cur_r;
        nm_wd = {{AW{1'b0}}, {AW{1'b0}}, CB'(1)};
        if (leaf_r) begin
          res_max_nxt = '0;
          res_st_nxt  = ST_OK;
          st_nxt      = S_FIN;
        end else begin
          if (kb) begin
            nm_wd[CB + AW +: AW] = fl_q;
          end else begin
            nm_wd[CB +: AW] = fl_q;
          end
          cur_nxt = fl_q;
          fc_nxt  = fc_r - FW'(1);
          if (lvl_r == '0) begin
            leaf_nxt = 1'b1;
          end else begin
            lvl_nxt = lvl_r - LW'(1);
          end
        end
      end
      S_WRE: begin
        if (first_r) begin
          par_nxt = nm_q;
        end else if (cnt_dec != '0) begin
          nm_we   = 1'b1;
          nm_wa   = cur_r;
          nm_wd   = {r_l1, r_l0, cnt_dec};
          par_nxt = {r_l1, r_l0, cnt_dec};
        end else begin
          // count hit zero: unlink from the parent and push onto the free stack
          nm_we = 1'b1;
          nm_wa = pa_r;
          nm_wd = par_r;
          if (pb_r) begin
            nm_wd[CB + AW +: AW] = '0;
          end else begin
            nm_wd[CB +: AW] = '0;
          end
          par_nxt = {r_l1, r_l0, cnt_dec};
          if (fc_r < FW'(NODES)) begin
            fl_we  = 1'b1;
            fl_wa  = fc_r[AW-1:0];
            fl_wd  = cur_r;
            fc_nxt = fc_r + FW'(1);
          end
        end
        first_nxt = 1'b0;
        if (leaf_r) begin
          res_max_nxt = '0;
          res_st_nxt  = ST_OK;
          st_nxt      = S_FIN;
        end else begin
          pa_nxt  = cur_r;
          pb_nxt  = kb;
          nm_ra   = rl_b;
          cur_nxt = rl_b;
          if (lvl_r == '0) begin
            leaf_nxt = 1'b1;
          end else begin
            lvl_nxt = lvl_r - LW'(1);
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          out_max_nxt   = res_max_r;
          out_st_nxt    = res_st_r;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // free stack top is read every cycle so a pop has it in the next cycle
  assign fl_ra = AW'(fc_nxt - FW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      clr_r       <= '0;
      fc_r        <= FW'(NODES - 1 - KEY_BITS);
      out_valid_r <= 1'b0;
      leaf_r      <= 1'b0;
      first_r     <= 1'b0;
      lvl_r       <= '0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      fc_r        <= fc_nxt;
      out_valid_r <= out_valid_nxt;
      leaf_r      <= leaf_nxt;
      first_r     <= first_nxt;
      lvl_r       <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    cur_r     <= cur_nxt;
    pa_r      <= pa_nxt;
    pb_r      <= pb_nxt;
    par_r     <= par_nxt;
    best_r    <= best_nxt;
    res_max_r <= res_max_nxt;
    res_st_r  <= res_st_nxt;
    out_max_r <= out_max_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign in_op.ready     = (st_r == S_IDLE);
  assign out_res.valid   = out_valid_r;
  assign out_res.max_xor = out_max_r;
  assign out_res.status  = out_st_r;

endmodule

// ----- verif/binary_trie_max_xor_checker.sv -----
module binary_trie_max_xor_checker import btx_pkg::*; #(
  parameter int KEY_BITS   = 31,
  parameter int NODES      = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  btx_op_if           op_mon,
  btx_res_if          res_mon,
  output int unsigned err_count,
  output int unsigned pending,
  output int unsigned n_checked,
  output int unsigned n_full,
  output int unsigned n_absent
);

  typedef struct packed {
    logic [VAL_W-1:0]  max_xor;
    logic [STAT_W-1:0] status;
  } trie_result_t;

  int unsigned  child [NODES][2];
  int unsigned  pass_cnt [NODES];
  int unsigned  free_stack [NODES];
  int unsigned  free_top;
  trie_result_t expected_q[$];

  localparam int unsigned CNT_MAX = (1 << COUNT_BITS) - 1;

  function automatic int unsigned pop_node();
    int unsigned n;
    free_top--;
    n = free_stack[free_top];
    child[n][0] = 0;
    child[n][1] = 0;
    pass_cnt[n] = 0;
    return n;
  endfunction

  function automatic logic [STAT_W-1:0] trie_insert(logic [VAL_W-1:0] k);
    int unsigned cur, nxt, needed;
    logic b;
    cur = 0;
    needed = 0;
    for (int lv = KEY_BITS - 1; lv >= 0; lv--) begin
      if (needed == 0) begin
        nxt = child[cur][k[lv]];
        if (nxt == 0) needed = 1;
        else cur = nxt;
      end else begin
        needed++;
      end
    end
    if (needed > free_top) return ST_FULL;
    cur = 0;
    for (int lv = KEY_BITS - 1; lv >= 0; lv--) begin
      b = k[lv];
      nxt = child[cur][b];
      if (nxt == 0) begin
        nxt = pop_node();
        child[cur][b] = nxt;
      end
      cur = nxt;
      if (pass_cnt[cur] < CNT_MAX) pass_cnt[cur]++;
    end
    return ST_OK;
  endfunction

  function automatic logic [STAT_W-1:0] trie_erase(logic [VAL_W-1:0] k);
    int unsigned cur, nxt;
    logic b;
    cur = 0;
    for (int lv = KEY_BITS - 1; lv >= 0; lv--) begin
      nxt = child[cur][k[lv]];
      if (nxt == 0) return ST_ABSENT;
      cur = nxt;
    end
    cur = 0;
    for (int lv = KEY_BITS - 1; lv >= 0; lv--) begin
      b = k[lv];
      nxt = child[cur][b];
      if (pass_cnt[nxt] > 0) pass_cnt[nxt]--;
      if (pass_cnt[nxt] == 0) begin
        child[cur][b] = 0;
        if (free_top < NODES) begin
          free_stack[free_top] = nxt;
          free_top++;
        end
      end
      cur = nxt;
    end
    return ST_OK;
  endfunction

  function automatic logic [VAL_W-1:0] best_xor(logic [VAL_W-1:0] k);
    int unsigned cur, oth, same;
    logic [VAL_W-1:0] acc;
    cur = 0;
    acc = '0;
    for (int lv = KEY_BITS - 1; lv >= 0; lv--) begin
      oth = child[cur][!k[lv]];
      same = child[cur][k[lv]];
      if (oth != 0) begin
        cur = oth;
        acc[lv] = 1'b1;
      end else if (same != 0) begin
        cur = same;
      end else begin
        return '0;
      end
    end
    return acc;
  endfunction

  function automatic void trie_clear();
    for (int i = 0; i < NODES; i++) begin
      child[i][0] = 0;
      child[i][1] = 0;
      pass_cnt[i] = 0;
    end
    free_top = 0;
    for (int i = NODES - 1; i >= 1; i--) begin
      free_stack[free_top] = i;
      free_top++;
    end
    void'(trie_insert('0));
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    trie_result_t r, w;
    if (!rst_n) begin
      trie_clear();
      expected_q.delete();
      err_count = 0;
      n_checked = 0;
      n_full = 0;
      n_absent = 0;
    end else begin
      if (op_mon.valid && op_mon.ready) begin
        r.max_xor = '0;
        r.status = ST_OK;
        case (op_mon.operation)
          OP_INSERT: r.status = trie_insert(op_mon.value);
          OP_ERASE:  r.status = trie_erase(op_mon.value);
          OP_QUERY:  r.max_xor = best_xor(op_mon.value);
          default: ;
        endcase
        expected_q.push_back(r);
      end
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected transfer", 32'(res_mon.max_xor), 32'(res_mon.status));
        end else begin
          w = expected_q.pop_front();
          n_checked++;
          if (w.status == ST_FULL) n_full++;
          if (w.status == ST_ABSENT) n_absent++;
          if (res_mon.max_xor !== w.max_xor) begin
            report("max_xor", 32'(res_mon.max_xor), 32'(w.max_xor));
          end
          if (res_mon.status !== w.status) begin
            report("status", 32'(res_mon.status), 32'(w.status));
          end
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

// ----- verif/binary_trie_max_xor_top_test.sv -----
module binary_trie_max_xor_top_test;
  import btx_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  int unsigned cycles = 0;
  int unsigned err_count, pending, n_checked, n_full, n_absent;
  logic [VAL_W-1:0] live_keys[$];
  logic [VAL_W-1:0] prefixes[8];

  btx_op_if  op_ch();
  btx_res_if res_ch();

  binary_trie_max_xor_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_op   (op_ch),
    .out_res (res_ch)
  );

  binary_trie_max_xor_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_mon    (op_ch),
    .res_mon   (res_ch),
    .err_count (err_count),
    .pending   (pending),
    .n_checked (n_checked),
    .n_full    (n_full),
    .n_absent  (n_absent)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("binary_trie_max_xor_top_test: errors");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // result side stalls: mostly ready, some short and a few long stalls
  initial begin
    int unsigned n;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      res_ch.ready <= 1'b1;
      n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 200) : $urandom_range(1, 20);
      repeat (n) @(posedge clk);
      n = gap_len();
      if (n > 0) begin
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_op(logic [OP_W-1:0] op, logic [VAL_W-1:0] v);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      op_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    op_ch.valid <= 1'b1;
    op_ch.operation <= op;
    op_ch.value <= v;
    // ready settles between edges, so look at it on the falling edge
    forever begin
      @(negedge clk);
      if (op_ch.ready) begin
        @(posedge clk);
        break;
      end
    end
  endtask

  task automatic add_key(logic [VAL_W-1:0] k);
    send_op(OP_INSERT, k);
    live_keys.push_back(k);
  endtask

  task automatic drop_random_key();
    int unsigned i;
    i = $urandom_range(0, live_keys.size() - 1);
    send_op(OP_ERASE, live_keys[i]);
    live_keys.delete(i);
  endtask

  function automatic logic [VAL_W-1:0] near_key();
    logic [VAL_W-1:0] k;
    int unsigned sh;
    sh = $urandom_range(1, 30);
    k = prefixes[$urandom_range(0, 7)];
    k = ((k >> sh) << sh) | (VAL_W'($urandom()) & ((31'd1 << sh) - 31'd1));
    return k;
  endfunction

  initial begin
    int unsigned r;
    logic [VAL_W-1:0] k;
    rst_n <= 1'b0;
    op_ch.valid <= 1'b0;
    op_ch.operation <= OP_INSERT;
    op_ch.value <= '0;
    for (int i = 0; i < 8; i++) prefixes[i] = VAL_W'($urandom());
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    live_keys.push_back('0);

    // directed: extremes, every operation, empty store, unknown opcode
    send_op(OP_QUERY, '0);
    send_op(OP_QUERY, '1);
    add_key('1);
    send_op(OP_QUERY, '0);
    send_op(OP_QUERY, 31'h2AAA_AAAA);
    add_key('1);
    send_op(OP_ERASE, 31'h4000_0000);
    send_op(OP_ERASE, 31'h7FFF_FFFE);
    send_op(OP_UNUSED, '1);
    drop_random_key();
    drop_random_key();
    drop_random_key();
    send_op(OP_QUERY, 31'h1234_5678);
    send_op(OP_ERASE, '0);
    send_op(OP_ERASE, '1);
    add_key(31'h4000_0000);
    add_key(31'h0000_0001);
    send_op(OP_QUERY, 31'h4000_0001);
    send_op(OP_QUERY, '1);

    // fill the node table until inserts are turned away, then probe and drain
    for (int i = 0; i < 170; i++) add_key(VAL_W'($urandom()));
    for (int i = 0; i < 20; i++) send_op(OP_QUERY, VAL_W'($urandom()));
    while (live_keys.size() > 10) drop_random_key();

    for (int i = 0; i < 1560; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        k = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom()) : near_key();
        if (live_keys.size() < 150) add_key(k);
        else send_op(OP_INSERT, k);
      end else if (r < 58) begin
        if (live_keys.size() > 0 && $urandom_range(0, 4) != 0) drop_random_key();
        else send_op(OP_ERASE, near_key());
      end else if (r < 96) begin
        send_op(OP_QUERY, ($urandom_range(0, 1) == 0) ? VAL_W'($urandom()) : near_key());
      end else begin
        send_op(OP_UNUSED, VAL_W'($urandom()));
      end
    end
    op_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("checked %0d results: %0d full-store rejects, %0d absent-key erases",
             n_checked, n_full, n_absent);
    if (err_count == 0 && pending == 0) begin
      $display("binary_trie_max_xor_top_test: clean");
    end else begin
      $display("binary_trie_max_xor_top_test: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/btx_pkg.sv
rtl/btx_op_if.sv
rtl/btx_res_if.sv
rtl/binary_trie_max_xor_top.sv
verif/binary_trie_max_xor_checker.sv
verif/binary_trie_max_xor_top_test.sv
